// File: rtl/core/qrs_pkg.sv
`timescale 1ns / 1ps
package qrs_pkg;

	localparam int ROOT_W = 34;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_REAL  = 2'd0,
		ST_IMAG  = 2'd1,
		ST_AZERO = 2'd2
	} status_t;

endpackage

// File: rtl/core/qrs_coef_if.sv
`timescale 1ns / 1ps
interface qrs_coef_if #(parameter int COEF_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COEF_WIDTH-1:0] coef_a;
	logic signed [COEF_WIDTH-1:0] coef_b;
	logic signed [COEF_WIDTH-1:0] coef_c;

	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// File: rtl/core/qrs_root_if.sv
`timescale 1ns / 1ps
interface qrs_root_if;
	logic                              valid;
	logic                              ready;
	logic [qrs_pkg::STATUS_W-1:0]      status;
	logic signed [qrs_pkg::ROOT_W-1:0] root_plus;
	logic signed [qrs_pkg::ROOT_W-1:0] root_minus;

	modport source (output valid, status, root_plus, root_minus, input ready);
	modport sink (input valid, status, root_plus, root_minus, output ready);
endinterface

// File: rtl/core/qrs_sqrt_pipe.sv
`timescale 1ns / 1ps
module qrs_sqrt_pipe #(
	parameter int XW = 66,
	parameter int SW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [XW-1:0]   in_x,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [XW/2-1:0] out_root,
	output logic [SW-1:0]   out_side
);
	localparam int RW = XW / 2;

	logic [RW+1:0] rem_s  [1:RW];
	logic [RW-1:0] root_s [1:RW];
	logic [XW-1:0] x_s    [1:RW];
	logic [SW-1:0] side_s [1:RW];
	logic          vld_s  [1:RW];

	for (genvar k = 1; k <= RW; k++) begin : g_step
		logic [RW+1:0] p_rem;
		logic [RW-1:0] p_root;
		logic [XW-1:0] p_x;
		logic [SW-1:0] p_side;
		logic          p_vld;
		logic [RW+3:0] cur;
		logic [RW+3:0] trial;
		logic          fit;

		if (k == 1) begin : g_first
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_x    = in_x;
			assign p_side = in_side;
			assign p_vld  = in_valid;
		end else begin : g_next
			assign p_rem  = rem_s[k-1];
			assign p_root = root_s[k-1];
			assign p_x    = x_s[k-1];
			assign p_side = side_s[k-1];
			assign p_vld  = vld_s[k-1];
		end

		assign cur   = {p_rem, p_x[XW-1:XW-2]};
		assign trial = (RW+4)'({p_root, 2'b01});
		assign fit   = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= fit ? (RW+2)'(cur - trial) : (RW+2)'(cur);
				root_s[k] <= {p_root[RW-2:0], fit};
				x_s[k]    <= p_x << 2;
				side_s[k] <= p_side;
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign out_root  = root_s[RW];
	assign out_side  = side_s[RW];

endmodule

// File: rtl/core/qrs_div_pipe.sv
`timescale 1ns / 1ps
module qrs_div_pipe #(
	parameter int NW  = 34,
	parameter int DVW = 17,
	parameter int SW  = 3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [NW-1:0]  in_num,
	input  logic [DVW-1:0] in_den,
	input  logic [SW-1:0]  in_side,
	output logic           out_valid,
	output logic [NW-1:0]  out_quot,
	output logic [SW-1:0]  out_side
);
	logic [DVW-1:0] rem_s  [1:NW];
	logic [NW-1:0]  q_s    [1:NW];
	logic [NW-1:0]  n_s    [1:NW];
	logic [DVW-1:0] den_s  [1:NW];
	logic [SW-1:0]  side_s [1:NW];
	logic           vld_s  [1:NW];

	for (genvar k = 1; k <= NW; k++) begin : g_step
		logic [DVW-1:0] p_rem;
		logic [NW-1:0]  p_q;
		logic [NW-1:0]  p_n;
		logic [DVW-1:0] p_den;
		logic [SW-1:0]  p_side;
		logic           p_vld;
		logic [DVW:0]   cur;
		logic           fit;

		if (k == 1) begin : g_first
			assign p_rem  = '0;
			assign p_q    = '0;
			assign p_n    = in_num;
			assign p_den  = in_den;
			assign p_side = in_side;
			assign p_vld  = in_valid;
		end else begin : g_next
			assign p_rem  = rem_s[k-1];
			assign p_q    = q_s[k-1];
			assign p_n    = n_s[k-1];
			assign p_den  = den_s[k-1];
			assign p_side = side_s[k-1];
			assign p_vld  = vld_s[k-1];
		end

		assign cur = {p_rem, p_n[NW-1]};
		assign fit = cur >= {1'b0, p_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= fit ? DVW'(cur - {1'b0, p_den}) : DVW'(cur);
				q_s[k]    <= {p_q[NW-2:0], fit};
				n_s[k]    <= p_n << 1;
				den_s[k]  <= p_den;
				side_s[k] <= p_side;
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign out_quot  = q_s[NW];
	assign out_side  = side_s[NW];

endmodule

// File: rtl/core/quadratic_root_solver_core.sv
// Throughput: one coefficient set per cycle; the square root and the two dividers
// are pipelined one result bit per stage.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
module quadratic_root_solver_core #(
	parameter int COEF_WIDTH = 16,
	parameter int FRAC_BITS  = 16
) (
	input logic      clk,
	input logic      arst_n,
	qrs_coef_if.sink coef,
	qrs_root_if.source root
);
	localparam int W   = COEF_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int DW  = 2 * W + 2;
	localparam int RW  = (DW + 2 * F + 1) / 2;
	localparam int XE  = 2 * RW;
	localparam int NBW = W + F + 1;
	localparam int NSW = RW + 2;
	localparam int NW  = RW + 1;
	localparam int DVW = W + 1;
	localparam int SQS = qrs_pkg::STATUS_W + NBW + 1 + DVW;
	localparam int QW  = qrs_pkg::ROOT_W;

	logic en;
	logic out_vld_q;

	assign en         = !out_vld_q || root.ready;
	assign coef.ready = en;

	// stage 1: magnitudes and products
	logic [W-1:0]     a_mag, b_mag, c_mag;
	logic             vld_s1;
	logic [2*W-1:0]   b2_s1, ac_s1;
	logic             neg_s1, azero_s1, asgn_s1;
	logic signed [W-1:0] b_s1;
	logic [W-1:0]     am_s1;

	assign a_mag = coef.coef_a[W-1] ? W'(-coef.coef_a) : W'(coef.coef_a);
	assign b_mag = coef.coef_b[W-1] ? W'(-coef.coef_b) : W'(coef.coef_b);
	assign c_mag = coef.coef_c[W-1] ? W'(-coef.coef_c) : W'(coef.coef_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= coef.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b2_s1    <= (2*W)'(b_mag) * (2*W)'(b_mag);
			ac_s1    <= (2*W)'(a_mag) * (2*W)'(c_mag);
			neg_s1   <= coef.coef_a[W-1] != coef.coef_c[W-1];
			azero_s1 <= coef.coef_a == '0;
			asgn_s1  <= coef.coef_a[W-1];
			b_s1     <= coef.coef_b;
			am_s1    <= a_mag;
		end
	end

	// stage 2: discriminant and classification
	logic [DW-1:0]         q4, b2w, d_c;
	logic                  imag;
	qrs_pkg::status_t      st_c;
	logic                  vld_s2;
	logic [DW-1:0]         d_s2;
	logic [SQS-1:0]        side_s2;
	logic signed [NBW-1:0] nb_c;

	assign q4   = DW'(ac_s1) << 2;
	assign b2w  = DW'(b2_s1);
	assign imag = !neg_s1 && (b2w < q4);
	assign d_c  = neg_s1 ? b2w + q4 : b2w - q4;
	assign nb_c = -(NBW'(b_s1) <<< F);

	always_comb begin
		if (azero_s1) begin
			st_c = qrs_pkg::ST_AZERO;
		end else if (imag) begin
			st_c = qrs_pkg::ST_IMAG;
		end else begin
			st_c = qrs_pkg::ST_REAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2    <= d_c;
			side_s2 <= {st_c, nb_c, asgn_s1, am_s1, 1'b0};
		end
	end

	// square root of D scaled by 2^(2F)
	logic           sq_vld;
	logic [RW-1:0]  sq_root;
	logic [SQS-1:0] sq_side;

	qrs_sqrt_pipe #(.XW(XE), .SW(SQS)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.in_x      (XE'(d_s2) << (2 * F)),
		.in_side   (side_s2),
		.out_valid (sq_vld),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// stage 3: numerators
	logic [qrs_pkg::STATUS_W-1:0] sq_st;
	logic signed [NBW-1:0]        sq_nb;
	logic                         sq_asgn;
	logic [DVW-1:0]               sq_den;
	logic signed [NSW-1:0]        np_c, nm_c;
	logic                         vld_s3;
	logic [NW-1:0]                np_s3, nm_s3;
	logic [DVW-1:0]               den_s3;
	logic [qrs_pkg::STATUS_W-1:0] st_s3;
	logic                         sp_s3, sm_s3;

	assign {sq_st, sq_nb, sq_asgn, sq_den} = sq_side;
	assign np_c = NSW'(sq_nb) + $signed({2'b00, sq_root});
	assign nm_c = NSW'(sq_nb) - $signed({2'b00, sq_root});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			np_s3  <= np_c[NSW-1] ? NW'(-np_c) : NW'(np_c);
			nm_s3  <= nm_c[NSW-1] ? NW'(-nm_c) : NW'(nm_c);
			sp_s3  <= np_c[NSW-1] ^ sq_asgn;
			sm_s3  <= nm_c[NSW-1] ^ sq_asgn;
			den_s3 <= sq_den;
			st_s3  <= sq_st;
		end
	end

	// magnitude division by |2a|
	logic                                 dp_vld, dm_vld;
	logic [NW-1:0]                        dp_q, dm_q;
	logic [qrs_pkg::STATUS_W:0]           dp_side;
	logic                                 dm_side;

	qrs_div_pipe #(.NW(NW), .DVW(DVW), .SW(qrs_pkg::STATUS_W + 1)) u_div_plus (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_num    (np_s3),
		.in_den    (den_s3),
		.in_side   ({st_s3, sp_s3}),
		.out_valid (dp_vld),
		.out_quot  (dp_q),
		.out_side  (dp_side)
	);

	qrs_div_pipe #(.NW(NW), .DVW(DVW), .SW(1)) u_div_minus (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_num    (nm_s3),
		.in_den    (den_s3),
		.in_side   (sm_s3),
		.out_valid (dm_vld),
		.out_quot  (dm_q),
		.out_side  (dm_side)
	);

	// output register: apply signs, drop roots for special cases
	logic signed [NW:0]           qp_c, qm_c;
	logic [qrs_pkg::STATUS_W-1:0] fin_st;
	logic                         fin_zero;
	logic [qrs_pkg::STATUS_W-1:0] st_q;
	logic signed [QW-1:0]         rp_q, rm_q;

	assign fin_st   = dp_side[qrs_pkg::STATUS_W:1];
	assign fin_zero = fin_st != qrs_pkg::ST_REAL;
	assign qp_c     = dp_side[0] ? -$signed({1'b0, dp_q}) : $signed({1'b0, dp_q});
	assign qm_c     = dm_side ? -$signed({1'b0, dm_q}) : $signed({1'b0, dm_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dp_vld && dm_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= fin_st;
			rp_q <= fin_zero ? '0 : QW'(qp_c);
			rm_q <= fin_zero ? '0 : QW'(qm_c);
		end
	end

	assign root.valid      = out_vld_q;
	assign root.status     = st_q;
	assign root.root_plus  = rp_q;
	assign root.root_minus = rm_q;

endmodule
